// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// shared sizes, status codes and control types of the stable priority queue
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    // queue geometry and field widths
    localparam int DEPTH       = 16;
    localparam int RANK_WIDTH  = 8;
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_WIDTH   = $clog2(DEPTH + 1);

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // request kinds carried in tuser
    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: holds an entry, shifts it on insert or removal
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire t_cell_ctrl             i_ctrl,
    input  wire logic                   i_occ,
    input  wire logic                   i_left_keep,
    input  wire logic [VALUE_WIDTH-1:0] i_left_value,
    input  wire logic [RANK_WIDTH-1:0]  i_left_rank,
    input  wire logic [VALUE_WIDTH-1:0] i_right_value,
    input  wire logic [RANK_WIDTH-1:0]  i_right_rank,
    input  wire logic [VALUE_WIDTH-1:0] i_new_value,
    input  wire logic [RANK_WIDTH-1:0]  i_new_rank,
    output logic                        o_keep,
    output logic [VALUE_WIDTH-1:0]      o_value,
    output logic [RANK_WIDTH-1:0]       o_rank
);

    logic [VALUE_WIDTH-1:0] r_value, n_value;
    logic [RANK_WIDTH-1:0]  r_rank, n_rank;

    // entry stays put when it is held and ranks at or before the new one
    assign o_keep  = i_occ && (r_rank <= i_new_rank);
    assign o_value = r_value;
    assign o_rank  = r_rank;

    // next slot contents
    always_comb begin
        n_value = r_value;
        n_rank  = r_rank;
        if (i_ctrl.enq && !o_keep) begin
            if (i_left_keep) begin
                n_value = i_new_value;
                n_rank  = i_new_rank;
            end else begin
                n_value = i_left_value;
                n_rank  = i_left_rank;
            end
        end else if (i_ctrl.deq) begin
            n_value = i_right_value;
            n_rank  = i_right_rank;
        end
    end

    // slot storage, no reset needed
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_rank  <= n_rank;
    end

endmodule

`default_nettype wire

// ===== rtl/stable_priority_queue_top.sv =====
// The result is registered and valid in the cycle after its request is accepted.
// Throughput: one request per cycle while the result side is not stalling; the
// output register is refilled in the same cycle its result is taken.
// Each accepted request that is not dropped shifts the cell chain at once.
// Reset (synchronous, active low) empties the queue and drops a pending result;
// slot contents are left as they are and never read while unoccupied.
// ----------------------------------------------------------------------------
// stable_priority_queue_top
// sorted chain of cells, lowest rank at the front, equal ranks in fifo order
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_queue_top
    import spq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [39:0] i_s_axis_tdata,  // item_value[31:0], item_rank[39:32]
    input  wire logic [0:0]  i_s_axis_tuser,  // mode[0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata,  // out_value[31:0], occupancy[36:32], zero pad
    output logic [1:0]       o_m_axis_tuser   // status[1:0]
);

    logic                   w_accept;
    logic                   w_is_deq;
    logic                   w_full;
    logic                   w_empty;
    t_cell_ctrl             w_ctrl;
    logic [VALUE_WIDTH-1:0] w_new_value;
    logic [RANK_WIDTH-1:0]  w_new_rank;

    logic [CNT_WIDTH-1:0]   r_count, n_count;
    logic                   r_out_valid;
    logic [VALUE_WIDTH-1:0] r_out_value, n_out_value;
    logic [1:0]             r_out_status, n_out_status;
    logic [CNT_WIDTH-1:0]   r_out_occ;

    logic [VALUE_WIDTH-1:0] w_value [DEPTH];
    logic [RANK_WIDTH-1:0]  w_rank  [DEPTH];
    logic                   w_keep  [DEPTH];

    // request decode
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_is_deq        = (i_s_axis_tuser[0] == MODE_DEQ);
    assign w_new_value     = i_s_axis_tdata[VALUE_WIDTH-1:0];
    assign w_new_rank      = i_s_axis_tdata[VALUE_WIDTH +: RANK_WIDTH];
    assign w_full          = (r_count == CNT_WIDTH'(DEPTH));
    assign w_empty         = (r_count == '0);
    assign w_ctrl.enq      = w_accept && !w_is_deq && !w_full;
    assign w_ctrl.deq      = w_accept && w_is_deq && !w_empty;

    // cell chain
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic                   w_lkeep;
        logic [VALUE_WIDTH-1:0] w_lval, w_rval;
        logic [RANK_WIDTH-1:0]  w_lrank, w_rrank;

        if (gi == 0) begin : g_head
            assign w_lkeep = 1'b1;
            assign w_lval  = w_new_value;
            assign w_lrank = w_new_rank;
        end else begin : g_mid
            assign w_lkeep = w_keep[gi-1];
            assign w_lval  = w_value[gi-1];
            assign w_lrank = w_rank[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign w_rval  = w_value[gi];
            assign w_rrank = w_rank[gi];
        end else begin : g_body
            assign w_rval  = w_value[gi+1];
            assign w_rrank = w_rank[gi+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_occ         (CNT_WIDTH'(gi) < r_count),
            .i_left_keep   (w_lkeep),
            .i_left_value  (w_lval),
            .i_left_rank   (w_lrank),
            .i_right_value (w_rval),
            .i_right_rank  (w_rrank),
            .i_new_value   (w_new_value),
            .i_new_rank    (w_new_rank),
            .o_keep        (w_keep[gi]),
            .o_value       (w_value[gi]),
            .o_rank        (w_rank[gi])
        );
    end

    // occupancy and result
    always_comb begin
        n_count      = r_count;
        n_out_value  = '0;
        n_out_status = ST_OK;
        if (w_ctrl.enq) begin
            n_count = r_count + 1'b1;
        end else if (w_ctrl.deq) begin
            n_count     = r_count - 1'b1;
            n_out_value = w_value[0];
        end
        if (w_is_deq && w_empty) begin
            n_out_status = ST_EMPTY;
        end else if (!w_is_deq && w_full) begin
            n_out_status = ST_FULL;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_value  <= n_out_value;
            r_out_status <= n_out_status;
            r_out_occ    <= n_count;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_occ, r_out_value};
    assign o_m_axis_tuser  = r_out_status;

endmodule

`default_nettype wire

// ===== rtl/spq_chk.sv =====
// ----------------------------------------------------------------------------
// spq_chk
// port-level checks on the priority queue results
// ----------------------------------------------------------------------------
`default_nettype none

module spq_chk
    import spq_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic [0:0]  i_s_axis_tuser,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [39:0] o_m_axis_tdata,
    input wire logic [1:0]  o_m_axis_tuser
);

    // empty dequeue reports nothing held and no data
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ST_EMPTY
        |-> o_m_axis_tdata == 40'd0)
        else $error("empty status with data or occupancy");

    // dropped enqueue only when the queue is full
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ST_FULL
        |-> o_m_axis_tdata[36:32] == 5'(DEPTH) && o_m_axis_tdata[31:0] == '0)
        else $error("full status with wrong occupancy");

    // occupancy never exceeds the depth, pad bits stay zero and status is a defined code
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[36:32] <= 5'(DEPTH)
        && o_m_axis_tdata[39:37] == 3'b000 && o_m_axis_tuser != 2'd3)
        else $error("result out of range");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready
        |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // an accepted enqueue request yields a result with no data
    a_enq_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser[0] == MODE_ENQ
        |=> o_m_axis_tvalid && o_m_axis_tdata[31:0] == '0 && o_m_axis_tuser != ST_EMPTY)
        else $error("enqueue result carries data");

endmodule

bind stable_priority_queue_top spq_chk u_spq_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

// ===== sim/stable_priority_queue_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stable_priority_queue_top_test
// self-checking bench for the sorted priority queue: a directed table covers
// empty and full handling and equal-rank ordering, then random segments with
// varying enqueue/dequeue bias and rank spread are checked against a shadow
// sorted list, with random stalls on both stream sides
// ----------------------------------------------------------------------------

module stable_priority_queue_top_test;

    import spq_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 1025;

    // one result as it leaves the block
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [1:0]             status;
        logic [CNT_WIDTH-1:0]   occ;
    } t_spq_result;

    // one directed request, with a typed-in result where has_exp is set
    typedef struct packed {
        logic                   mode;
        logic [VALUE_WIDTH-1:0] value;
        logic [RANK_WIDTH-1:0]  rank;
        logic                   has_exp;
        logic [VALUE_WIDTH-1:0] exp_value;
        logic [1:0]             exp_status;
        logic [CNT_WIDTH-1:0]   exp_occ;
    } t_stim_row;

    // directed table: empty dequeue, extremes, equal-rank order, fill to full
    localparam t_stim_row DIRECTED_ROWS [25] = '{
        '{MODE_DEQ, 32'hFFFF_FFFF, 8'hFF, 1'b1, 32'h0000_0000, ST_EMPTY, 5'd0},
        '{MODE_ENQ, 32'hFFFF_FFFF, 8'hFF, 1'b1, 32'h0000_0000, ST_OK,    5'd1},
        '{MODE_ENQ, 32'h0000_0000, 8'h00, 1'b1, 32'h0000_0000, ST_OK,    5'd2},
        '{MODE_ENQ, 32'hA5A5_5A5A, 8'hFF, 1'b1, 32'h0000_0000, ST_OK,    5'd3},
        '{MODE_DEQ, 32'h1234_5678, 8'hFF, 1'b1, 32'h0000_0000, ST_OK,    5'd2},
        '{MODE_DEQ, 32'h0000_0000, 8'h00, 1'b1, 32'hFFFF_FFFF, ST_OK,    5'd1},
        '{MODE_DEQ, 32'h0000_0000, 8'h00, 1'b1, 32'hA5A5_5A5A, ST_OK,    5'd0},
        '{MODE_DEQ, 32'h0000_0000, 8'h00, 1'b1, 32'h0000_0000, ST_EMPTY, 5'd0},
        '{MODE_ENQ, 32'h0000_0001, 8'h80, 1'b0, 32'h0, ST_OK, 5'd0},
        '{MODE_ENQ, 32'h8000_0000, 8'h01, 1'b0, 32'h0, ST_OK, 5'd0},
        '{MODE_ENQ, 32'h5555_5555, 8'h80, 1'b0, 32'h0, ST_OK, 5'd0},
        '{MODE_ENQ, 32'hAAAA_AAAA, 8'hFE, 1'b0, 32'h0, ST_OK, 5'd0},
        '{MODE_ENQ, 32'h0000_0010, 8'h01, 1'b0, 32'h0, ST_OK, 5'd0},
        '{MODE_ENQ, 32'h0000_0100, 8'h80, 1'b0, 32'h0, ST_OK, 5'd0},
        '{MODE_ENQ, 32'h0000_1000, 8'h00, 1'b0, 32'h0, ST_OK, 5'd0},
        '{MODE_ENQ, 32'h0001_0000, 8'hFF, 1'b0, 32'h0, ST_OK, 5'd0},
        '{MODE_ENQ, 32'h0010_0000, 8'h7F, 1'b0, 32'h0, ST_OK, 5'd0},
        '{MODE_ENQ, 32'h0100_0000, 8'h80, 1'b0, 32'h0, ST_OK, 5'd0},
        '{MODE_ENQ, 32'h1000_0000, 8'h01, 1'b0, 32'h0, ST_OK, 5'd0},
        '{MODE_ENQ, 32'hF0F0_F0F0, 8'hFE, 1'b0, 32'h0, ST_OK, 5'd0},
        '{MODE_ENQ, 32'h0F0F_0F0F, 8'h00, 1'b0, 32'h0, ST_OK, 5'd0},
        '{MODE_ENQ, 32'hCAFE_F00D, 8'hFF, 1'b0, 32'h0, ST_OK, 5'd0},
        '{MODE_ENQ, 32'h3C3C_C3C3, 8'h7F, 1'b0, 32'h0, ST_OK, 5'd0},
        '{MODE_ENQ, 32'h7FFF_FFFE, 8'h80, 1'b0, 32'h0, ST_OK, 5'd0},
        '{MODE_ENQ, 32'hDEAD_BEEF, 8'h00, 1'b1, 32'h0000_0000, ST_FULL, 5'(DEPTH)}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata = '0;  // item_value[31:0], item_rank[39:32]
    logic [0:0]  i_s_axis_tuser = '0;  // mode[0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;       // out_value[31:0], occupancy[36:32], zero pad
    logic [1:0]  o_m_axis_tuser;       // status[1:0]

    // shadow copy of the sorted list
    logic [VALUE_WIDTH-1:0] shadow_value [DEPTH];
    logic [RANK_WIDTH-1:0]  shadow_rank [DEPTH];
    int                     shadow_count = 0;

    t_spq_result pending_results [$];

    int  cycle_count   = 0;
    int  error_count   = 0;
    int  checked_count = 0;
    int  enq_count     = 0;
    int  deq_count     = 0;
    int  full_count    = 0;
    int  empty_count   = 0;
    bit  steady        = 1'b0;
    int unsigned rx_hold = 0;

    stable_priority_queue_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // mostly short gaps, a few long ones, none in steady stretches
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // sorted insert behind equal ranks, or removal of the front entry
    function automatic t_spq_result predict_queue_result(input logic mode,
                                                         input logic [VALUE_WIDTH-1:0] value,
                                                         input logic [RANK_WIDTH-1:0] rank);
        t_spq_result res;
        int          pos;
        int          i;
        res = '0;
        if (mode == MODE_ENQ) begin
            if (shadow_count >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < shadow_count && shadow_rank[pos] <= rank)
                    pos++;
                for (i = shadow_count; i > pos; i--) begin
                    shadow_value[i] = shadow_value[i-1];
                    shadow_rank[i]  = shadow_rank[i-1];
                end
                shadow_value[pos] = value;
                shadow_rank[pos]  = rank;
                shadow_count++;
                res.status = ST_OK;
            end
        end else begin
            if (shadow_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.value = shadow_value[0];
                for (i = 1; i < shadow_count; i++) begin
                    shadow_value[i-1] = shadow_value[i];
                    shadow_rank[i-1]  = shadow_rank[i];
                end
                shadow_count--;
                res.status = ST_OK;
            end
        end
        res.occ = CNT_WIDTH'(shadow_count);
        return res;
    endfunction

    // present one request, wait for the handshake, then idle for the requested gap
    task automatic send_request(input logic mode,
                                input logic [VALUE_WIDTH-1:0] value,
                                input logic [RANK_WIDTH-1:0] rank,
                                input logic has_exp,
                                input t_spq_result typed_res,
                                input int unsigned gap);
        t_spq_result res;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {rank, value};
        i_s_axis_tuser  <= mode;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        res = predict_queue_result(mode, value, rank);
        pending_results.push_back(has_exp ? typed_res : res);
        if (mode == MODE_ENQ)
            enq_count++;
        else
            deq_count++;
        if (res.status == ST_FULL)
            full_count++;
        if (res.status == ST_EMPTY)
            empty_count++;
        if (gap != 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // drop valid and hold off until every outstanding result is back
    task automatic drain_results();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] got_val);
        if (got_val !== exp_val) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
            error_count++;
        end
    endfunction

    // result side: random back-pressure
    always @(negedge i_clk) begin
        if (rx_hold != 0) begin
            i_m_axis_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            i_m_axis_tready <= 1'b1;
            rx_hold = pick_gap();
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_spq_result exp_res;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result 0x%0h / status %0d with no request outstanding",
                       o_m_axis_tdata, o_m_axis_tuser);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                check_field("out_value", exp_res.value, o_m_axis_tdata[31:0]);
                check_field("occupancy", 32'(exp_res.occ), 32'(o_m_axis_tdata[36:32]));
                check_field("tdata pad", 32'd0, 32'(o_m_axis_tdata[39:37]));
                check_field("status", 32'(exp_res.status), 32'(o_m_axis_tuser));
                checked_count++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("stable_priority_queue_top regression: fail");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_stim_row              row;
        int                     sent;
        int                     seg_len;
        int                     seg_index;
        int                     enq_pct;
        int                     rank_style;
        logic [RANK_WIDTH-1:0]  seg_rank;
        logic [RANK_WIDTH-1:0]  rank;
        logic                   mode;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (DIRECTED_ROWS[r]) begin
            row = DIRECTED_ROWS[r];
            send_request(row.mode, row.value, row.rank, row.has_exp,
                         {row.exp_value, row.exp_status, row.exp_occ}, pick_gap());
        end
        drain_results();

        // random segments with varying bias and rank spread
        sent = 0;
        seg_index = 0;
        while (sent < RANDOM_ITEMS) begin
            seg_len    = $urandom_range(15, 80);
            if (seg_len > RANDOM_ITEMS - sent)
                seg_len = RANDOM_ITEMS - sent;
            rank_style = $urandom_range(0, 3);
            seg_rank   = RANK_WIDTH'($urandom);
            steady     = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0: enq_pct = 80;
                1: enq_pct = 50;
                default: enq_pct = 20;
            endcase
            repeat (seg_len) begin
                mode = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
                case (rank_style)
                    0: rank = seg_rank;
                    1: rank = RANK_WIDTH'($urandom_range(0, 3));
                    2: rank = RANK_WIDTH'($urandom);
                    default: rank = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                endcase
                send_request(mode, $urandom, rank, 1'b0, '0, pick_gap());
                sent++;
            end
            // hold the sender until the queue side has caught up
            if (seg_index == 3 || $urandom_range(0, 99) < 15)
                drain_results();
            seg_index++;
        end
        steady = 1'b0;

        drain_results();
        repeat (10) @(posedge i_clk);

        $display("covered %0d requests: %0d enqueue, %0d dequeue,",
                 enq_count + deq_count, enq_count, deq_count);
        $display("  %0d full drops, %0d empty dequeues, %0d results checked in %0d cycles",
                 full_count, empty_count, checked_count, cycle_count);
        $display("%0d mismatches", error_count);
        if (error_count == 0)
            $display("stable_priority_queue_top regression: pass");
        else
            $display("stable_priority_queue_top regression: fail");
        $finish;
    end

endmodule
